[hdl/erk_pkg.sv]
// ----------------------------------------------------------------------------
// erk_pkg: shared types and constants
// Fixed-point constants, the CORDIC arctangent table and the beat structs that
// travel down the rotation and divider cell chains.
// ----------------------------------------------------------------------------
package erk_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_N           = 24;

  // Q.30 constants
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam int QW   = 33;  // quotient bits kept by the divider
  localparam int REMW = 65;  // remainder width

  // atan(2^-i) in Q.30, truncated
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      default: v = 34'sd127;
    endcase
    return v;
  endfunction

  // Rotation beat: two angles side by side plus the body rates
  typedef struct packed {
    logic signed [33:0] xa;
    logic signed [33:0] ya;
    logic signed [33:0] za;
    logic signed [33:0] xb;
    logic signed [33:0] yb;
    logic signed [33:0] zb;
    logic               nega;
    logic               negb;
    logic signed [31:0] p;
    logic signed [31:0] q;
    logic signed [31:0] r;
  } cord_t;

  // Data that rides along with the division
  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] st;
    logic signed [31:0] pitch;
    logic               pitch_ovf;
    logic               neg;
    logic               big;
  } dside_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [31:0]     den;
    logic [QW-1:0]   quo;
    dside_t          side;
  } div_t;

endpackage

[hdl/erk_cordic_cell.sv]
// ----------------------------------------------------------------------------
// erk_cordic_cell: one CORDIC rotation step
// Rotates both angle vectors by atan(2^-STEP) and registers the beat.
// ----------------------------------------------------------------------------
module erk_cordic_cell
  import erk_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  cord_t in_d,
  output logic  out_valid,
  output cord_t out_d
);

  localparam logic signed [33:0] ATAN = atan_q30(STEP);

  cord_t nxt;

  // rotate toward zero residual angle
  always_comb begin
    nxt = in_d;
    if (!in_d.za[33]) begin
      nxt.xa = in_d.xa - (in_d.ya >>> STEP);
      nxt.ya = in_d.ya + (in_d.xa >>> STEP);
      nxt.za = in_d.za - ATAN;
    end else begin
      nxt.xa = in_d.xa + (in_d.ya >>> STEP);
      nxt.ya = in_d.ya - (in_d.xa >>> STEP);
      nxt.za = in_d.za + ATAN;
    end
    if (!in_d.zb[33]) begin
      nxt.xb = in_d.xb - (in_d.yb >>> STEP);
      nxt.yb = in_d.yb + (in_d.xb >>> STEP);
      nxt.zb = in_d.zb - ATAN;
    end else begin
      nxt.xb = in_d.xb + (in_d.yb >>> STEP);
      nxt.yb = in_d.yb - (in_d.xb >>> STEP);
      nxt.zb = in_d.zb + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= nxt;
    end
  end

endmodule

[hdl/erk_div_cell.sv]
// ----------------------------------------------------------------------------
// erk_div_cell: one restoring division step
// Tries to take den << SHIFT off the remainder and shifts in a quotient bit.
// ----------------------------------------------------------------------------
module erk_div_cell
  import erk_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  div_t in_d,
  output logic out_valid,
  output div_t out_d
);

  logic [REMW-1:0] dsh;
  logic            ge;
  div_t            nxt;

  // compare, subtract, shift quotient
  always_comb begin
    dsh = {{(REMW-32){1'b0}}, in_d.den} << SHIFT;
    ge  = (in_d.rem >= dsh);
    nxt = in_d;
    nxt.rem = ge ? (in_d.rem - dsh) : in_d.rem;
    nxt.quo = {in_d.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= nxt;
    end
  end

endmodule

[hdl/euler_rate_kinematics.sv]
// ----------------------------------------------------------------------------
// euler_rate_kinematics: 3-2-1 Euler angle rates from body rates
// Pipelined CORDIC, clamped cos(pitch), restoring divider and product stages.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one beat per sample: roll and pitch angles (Q3.13) and the
//   body rates p, q, r (Q16.16). m_axis returns one beat per sample with the
//   roll, pitch and yaw rates (Q16.16); tuser flags an overflow, in which case
//   all three rates read zero.
//   cfg_we/cfg_wdata load cos_floor (Q0.15), the minimum |cos(pitch)|; write
//   it only while the pipeline is empty. Zero acts as one LSB.
//   Throughput: one beat per cycle while m_axis_tready keeps the chain moving.
//   The chain is one rotation cell per CORDIC step (at most 24), 33 divider
//   cells for the quotient bits and six product and clamp stages.
//   Reset clears every stage's valid bit and loads cos_floor with 33.
//   When m_axis_tready is low with a result waiting, the whole chain holds
//   and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module euler_rate_kinematics
  import erk_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // roll_angle[15:0], pitch_angle[31:16], rate_p[63:32], rate_q[95:64],
  // rate_r[127:96]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_rate[31:0], pitch_rate[63:32], yaw_rate[95:64]
  output logic [95:0]  m_axis_tdata,
  // overflow[0]
  output logic [0:0]   m_axis_tuser
);

  localparam int NSTEP = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;

  logic        adv;
  logic [14:0] cos_floor;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_floor <= 15'd33;
    end else if (cfg_we) begin
      cos_floor <= cfg_wdata;
    end
  end

  // advance the whole chain unless a result waits
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // range-reduce both angles into the CORDIC start beat
  cord_t              c_in;
  logic signed [33:0] z_a;
  logic signed [33:0] z_b;

  always_comb begin
    z_a = {s_axis_tdata[15], s_axis_tdata[15:0], 17'b0};
    z_b = {s_axis_tdata[31], s_axis_tdata[31:16], 17'b0};
    c_in.xa = GAIN_Q30;
    c_in.ya = '0;
    c_in.xb = GAIN_Q30;
    c_in.yb = '0;
    c_in.nega = 1'b0;
    c_in.negb = 1'b0;
    c_in.za = z_a;
    c_in.zb = z_b;
    if (z_a > HALF_PI_Q30) begin
      c_in.za = z_a - PI_Q30;
      c_in.nega = 1'b1;
    end else if (z_a < -HALF_PI_Q30) begin
      c_in.za = z_a + PI_Q30;
      c_in.nega = 1'b1;
    end
    if (z_b > HALF_PI_Q30) begin
      c_in.zb = z_b - PI_Q30;
      c_in.negb = 1'b1;
    end else if (z_b < -HALF_PI_Q30) begin
      c_in.zb = z_b + PI_Q30;
      c_in.negb = 1'b1;
    end
    c_in.p = s_axis_tdata[63:32];
    c_in.q = s_axis_tdata[95:64];
    c_in.r = s_axis_tdata[127:96];
  end

  // CORDIC chain
  cord_t c_d [NSTEP+1];
  logic  c_v [NSTEP+1];

  assign c_d[0] = c_in;
  assign c_v[0] = s_axis_tvalid;

  for (genvar i = 0; i < NSTEP; i++) begin : g_cord
    erk_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (c_v[i]),
      .in_d      (c_d[i]),
      .out_valid (c_v[i+1]),
      .out_d     (c_d[i+1])
    );
  end

  // stage 1: fold sign, clamp cos(pitch)
  logic signed [33:0] sa_w, ca_w, sb_w, cb_w, cb_abs, flr;
  logic signed [31:0] s1_sp, s1_cp, s1_st, s1_ct, s1_p, s1_q, s1_r;
  logic               s1_v;

  always_comb begin
    sa_w   = c_d[NSTEP].nega ? -c_d[NSTEP].ya : c_d[NSTEP].ya;
    ca_w   = c_d[NSTEP].nega ? -c_d[NSTEP].xa : c_d[NSTEP].xa;
    sb_w   = c_d[NSTEP].negb ? -c_d[NSTEP].yb : c_d[NSTEP].yb;
    cb_w   = c_d[NSTEP].negb ? -c_d[NSTEP].xb : c_d[NSTEP].xb;
    flr    = {4'b0, ((cos_floor == 15'd0) ? 15'd1 : cos_floor), 15'b0};
    cb_abs = cb_w[33] ? -cb_w : cb_w;
    if (cb_abs < flr) begin
      cb_w = cb_w[33] ? -flr : flr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= c_v[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sp <= sa_w[31:0];
      s1_cp <= ca_w[31:0];
      s1_st <= sb_w[31:0];
      s1_ct <= cb_w[31:0];
      s1_p  <= c_d[NSTEP].p;
      s1_q  <= c_d[NSTEP].q;
      s1_r  <= c_d[NSTEP].r;
    end
  end

  // stage 2: the four products
  logic signed [63:0] s2_sq, s2_cr, s2_cq, s2_sr;
  logic signed [31:0] s2_st, s2_ct, s2_p;
  logic               s2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sq <= s1_sp * s1_q;
      s2_cr <= s1_cp * s1_r;
      s2_cq <= s1_cp * s1_q;
      s2_sr <= s1_sp * s1_r;
      s2_st <= s1_st;
      s2_ct <= s1_ct;
      s2_p  <= s1_p;
    end
  end

  // stage 3: sums, pitch rounding, magnitudes for the divider
  logic signed [64:0] t_w, pv_w, pr_w, ta_w;
  logic signed [31:0] ca_abs;
  logic [63:0]        s3_num;
  logic [31:0]        s3_den;
  dside_t             s3_side;
  logic               s3_v;

  always_comb begin
    t_w    = {s2_sq[63], s2_sq} + {s2_cr[63], s2_cr};
    pv_w   = {s2_cq[63], s2_cq} - {s2_sr[63], s2_sr};
    pr_w   = (pv_w + 65'sd536870912) >>> 30;
    ta_w   = t_w[64] ? -t_w : t_w;
    ca_abs = s2_ct[31] ? -s2_ct : s2_ct;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_num            <= ta_w[63:0];
      s3_den            <= ca_abs;
      s3_side.p         <= s2_p;
      s3_side.st        <= s2_st;
      s3_side.pitch     <= pr_w[31:0];
      s3_side.pitch_ovf <= !((&pr_w[64:31]) || !(|pr_w[64:31]));
      s3_side.neg       <= t_w[64] ^ s2_ct[31];
      s3_side.big       <= 1'b0;
    end
  end

  // stage 4: flag quotients too large for the divider
  div_t   d_in;
  logic   d_in_v;
  dside_t d_side_w;

  always_comb begin
    d_side_w     = s3_side;
    d_side_w.big = ({1'b0, s3_num} >= {s3_den, 33'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_in_v <= 1'b0;
    end else if (adv) begin
      d_in_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_in.rem  <= {1'b0, s3_num};
      d_in.den  <= s3_den;
      d_in.quo  <= '0;
      d_in.side <= d_side_w;
    end
  end

  // divider chain, one quotient bit per cell
  div_t d_d [QW+1];
  logic d_v [QW+1];

  assign d_d[0] = d_in;
  assign d_v[0] = d_in_v;

  for (genvar j = 0; j < QW; j++) begin : g_div
    erk_div_cell #(.SHIFT(QW-1-j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (d_v[j]),
      .in_d      (d_d[j]),
      .out_valid (d_v[j+1]),
      .out_d     (d_d[j+1])
    );
  end

  // stage 5: signed yaw, range check, yaw * sin(pitch)
  logic signed [33:0] yaw_w;
  logic               yovf_w;
  logic signed [31:0] s5_yaw, s5_p, s5_pitch;
  logic signed [63:0] s5_prod;
  logic               s5_yovf, s5_povf, s5_v;
  dside_t             dq;

  always_comb begin
    dq     = d_d[QW].side;
    yaw_w  = dq.neg ? -$signed({1'b0, d_d[QW].quo}) : $signed({1'b0, d_d[QW].quo});
    yovf_w = dq.big || (dq.neg ? (d_d[QW].quo > 33'h080000000)
                               : (d_d[QW].quo > 33'h07FFFFFFF));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= d_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_yaw   <= yaw_w[31:0];
      s5_prod  <= $signed(yaw_w[31:0]) * dq.st;
      s5_yovf  <= yovf_w;
      s5_povf  <= dq.pitch_ovf;
      s5_pitch <= dq.pitch;
      s5_p     <= dq.p;
    end
  end

  // stage 6: round, add p, zero all on overflow; output register
  logic signed [63:0] rr_w;
  logic signed [36:0] roll_w;
  logic               ovf_w;

  always_comb begin
    rr_w   = (s5_prod + 64'sd536870912) >>> 30;
    roll_w = {rr_w[35], rr_w[35:0]} + {{5{s5_p[31]}}, s5_p};
    ovf_w  = s5_yovf || s5_povf ||
             !((&roll_w[36:31]) || !(|roll_w[36:31]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata[31:0]  <= ovf_w ? 32'd0 : roll_w[31:0];
      m_axis_tdata[63:32] <= ovf_w ? 32'd0 : s5_pitch;
      m_axis_tdata[95:64] <= ovf_w ? 32'd0 : s5_yaw;
      m_axis_tuser        <= ovf_w;
    end
  end

endmodule

[tb/euler_rate_kinematics_check.sv]
// ----------------------------------------------------------------------------
// euler_rate_kinematics_check: result predictor and scoreboard
// Watches the input, output and configuration ports, works out the expected
// Euler rates for every accepted input beat and compares output beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_rate_kinematics_check
  import erk_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic signed [31:0] yaw;
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
    logic               ovf;
  } rates_t;

  longint atan_tab [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127};

  logic [14:0] floor_reg;
  rates_t      rates_q[$];

  // Rotation-mode CORDIC with quadrant fold, Q3.13 angle in, Q.30 sine and cosine out
  function automatic void sin_cos(input logic signed [15:0] ang, output longint s,
                                  output longint c);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang) * 131072;
    x = longint'(GAIN_Q30);
    y = 0;
    flip = 0;
    if (z > longint'(HALF_PI_Q30)) begin
      z -= longint'(PI_Q30);
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z += longint'(PI_Q30);
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic bit fits32(longint v);
    return v >= -64'sd2147483648 && v <= 64'sd2147483647;
  endfunction

  function automatic longint rnd30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic rates_t euler_rates(logic [127:0] d, logic [14:0] flr);
    rates_t res;
    longint sp, cp, st, ct, f, t, yaw, roll, pitch;
    longint p, q, r;
    bit     ovf;
    p = longint'($signed(d[63:32]));
    q = longint'($signed(d[95:64]));
    r = longint'($signed(d[127:96]));
    sin_cos(d[15:0], sp, cp);
    sin_cos(d[31:16], st, ct);
    // clamp |cos(pitch)| to the floor, keeping the sign
    f = longint'(flr == 0 ? 15'd1 : flr) * 32768;
    if ((ct < 0 ? -ct : ct) < f) ct = (ct >= 0) ? f : -f;
    t = sp * q + cp * r;
    yaw = t / ct;
    pitch = rnd30(cp * q - sp * r);
    roll = 0;
    ovf = 0;
    if (!fits32(yaw)) ovf = 1;
    else begin
      roll = p + rnd30(yaw * st);
      if (!fits32(roll)) ovf = 1;
    end
    if (!fits32(pitch)) ovf = 1;
    if (ovf) begin
      roll = 0; pitch = 0; yaw = 0;
    end
    res.roll = roll[31:0];
    res.pitch = pitch[31:0];
    res.yaw = yaw[31:0];
    res.ovf = ovf;
    return res;
  endfunction

  assign pending = rates_q.size();

  // Track config, push predictions, compare output beats
  always @(posedge clk) begin
    rates_t want;
    if (rst) begin
      floor_reg <= 15'd33;
      rates_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) floor_reg <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        rates_q.push_back(euler_rates(s_axis_tdata, floor_reg));
      if (m_axis_tvalid && m_axis_tready) begin
        if (rates_q.size() == 0) begin
          $display("%0t: unexpected output beat %h ovf %b", $time, m_axis_tdata,
                   m_axis_tuser);
          errors <= errors + 1;
        end else begin
          want = rates_q.pop_front();
          if (m_axis_tdata[31:0] !== want.roll || m_axis_tdata[63:32] !== want.pitch
              || m_axis_tdata[95:64] !== want.yaw || m_axis_tuser[0] !== want.ovf) begin
            $display("%0t: mismatch expected roll %h pitch %h yaw %h ovf %b",
                     $time, want.roll, want.pitch, want.yaw, want.ovf);
            $display("%0t:          actual   roll %h pitch %h yaw %h ovf %b",
                     $time, m_axis_tdata[31:0], m_axis_tdata[63:32],
                     m_axis_tdata[95:64], m_axis_tuser[0]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[tb/euler_rate_kinematics_test.sv]
// ----------------------------------------------------------------------------
// euler_rate_kinematics_test: stimulus and verdict
// Drives directed and random angle/rate beats through several cos_floor
// settings and back-pressure patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_rate_kinematics_test;
  import erk_pkg::*;

  localparam int LATENCY = CORDIC_STEPS_DEF + 39;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [14:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           errors, pending;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  euler_rate_kinematics u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  euler_rate_kinematics_check u_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .errors(errors), .pending(pending)
  );

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_axis_tready <= 0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one beat, with random idle gaps ahead of it
  task automatic send_beat(input logic [15:0] roll, input logic [15:0] pitch,
                           input logic [31:0] p, input logic [31:0] q,
                           input logic [31:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {r, q, p, pitch, roll};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'($urandom_range(12860, 12880));              // near +pi/2
      1: return 16'(-$signed(16'($urandom_range(12860, 12880))));
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      3: return 16'($urandom_range(25700, 25740));              // near pi
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(3))
      0: return 32'($signed(17'($urandom)));                    // small
      1: return 32'($signed(24'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  // Let the pipeline empty, then load a new floor
  task automatic drain_and_set(input logic [14:0] flr);
    s_axis_tvalid <= 0;
    wait (pending == 0);
    repeat (LATENCY + 5) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= flr;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [14:0] floors [6];
    floors = '{15'd33, 15'd1, 15'd32767, 15'd0, 15'd33, 15'd33};
    floors[4] = 15'($urandom_range(2, 32766));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: angle extremes, quadrant edges, rate extremes, exact pi/2
    send_beat(16'h0000, 16'h0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_beat(16'h7fff, 16'h8000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_beat(16'h8000, 16'h7fff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_beat(16'd12868, 16'd12868, 32'h0, 32'h0001_0000, 32'h0001_0000);
    send_beat(16'd12869, 16'd12869, 32'h0, 32'h0001_0000, 32'hffff_0000);
    send_beat(-16'sd12868, -16'sd12869, 32'h0, 32'hffff_0000, 32'h0001_0000);
    send_beat(16'd25736, 16'd25736, 32'h1234_5678, 32'h0100_0000, 32'h0100_0000);
    send_beat(-16'sd25736, 16'd12868, 32'hffffffff, 32'h7fffffff, 32'h7fffffff);
    send_beat(16'hffff, 16'h0001, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_beat(16'h5555, 16'haaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_beat(16'haaaa, 16'h5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    send_beat(16'h0000, 16'd12868, 32'h0, 32'h0, 32'h0000_0001);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) drain_and_set(floors[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      // Long receiver hold-off so the pipeline fills and stalls its input
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_cycles = 300;
      end
      for (int n = 0; n < 150; n++)
        send_beat(pick_angle(), pick_angle(), pick_rate(), pick_rate(), pick_rate());
    end

    s_axis_tvalid <= 0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[euler_rate_kinematics.f]
hdl/erk_pkg.sv
hdl/erk_cordic_cell.sv
hdl/erk_div_cell.sv
hdl/euler_rate_kinematics.sv
tb/euler_rate_kinematics_check.sv
tb/euler_rate_kinematics_test.sv
